/* rtl/ifpl_pkg.sv */
// Shared types, codes and the frame status map of the inverter fault latch.
`default_nettype none

package ifpl_pkg;

    // Item kinds.
    localparam logic [1:0] FUNC_CHECK    = 2'd0;
    localparam logic [1:0] FUNC_CAPTURE  = 2'd1;
    localparam logic [1:0] FUNC_EXTERNAL = 2'd2;
    localparam logic [1:0] FUNC_CLEAR    = 2'd3;

    // Frame status codes.
    localparam logic [3:0] STAT_VALID          = 4'd0;
    localparam logic [3:0] STAT_OVERRUN        = 4'd1;
    localparam logic [3:0] STAT_QUEUE_OVERRUN  = 4'd2;
    localparam logic [3:0] STAT_DESYNC         = 4'd3;
    localparam logic [3:0] STAT_EOS_TIMEOUT    = 4'd4;
    localparam logic [3:0] STAT_NOT_ARMED      = 4'd5;
    localparam logic [3:0] STAT_WINDOW_BAD     = 4'd6;
    localparam logic [3:0] STAT_MAP_UNVERIFIED = 4'd7;
    localparam logic [3:0] STAT_CAL_BAD        = 4'd8;
    localparam logic [3:0] STAT_SATURATED      = 4'd9;

    // Fault reason codes.
    localparam logic [3:0] CODE_NONE          = 4'd0;
    localparam logic [3:0] CODE_OVERCURRENT   = 4'd1;
    localparam logic [3:0] CODE_BUS_HIGH      = 4'd2;
    localparam logic [3:0] CODE_BUS_LOW       = 4'd3;
    localparam logic [3:0] CODE_OVERRUN       = 4'd4;
    localparam logic [3:0] CODE_QUEUE_OVERRUN = 4'd5;
    localparam logic [3:0] CODE_DESYNC        = 4'd6;
    localparam logic [3:0] CODE_TIMEOUT       = 4'd7;
    localparam logic [3:0] CODE_WINDOW        = 4'd8;
    localparam logic [3:0] CODE_MAP           = 4'd9;
    localparam logic [3:0] CODE_FRAME_COPY    = 4'd10;

    // Clear request results.
    localparam logic [2:0] CLR_OK             = 3'd0;
    localparam logic [2:0] CLR_NOT_LATCHED    = 3'd1;
    localparam logic [2:0] CLR_CONTROL_ACTIVE = 3'd2;
    localparam logic [2:0] CLR_UNSAFE         = 3'd3;
    localparam logic [2:0] CLR_SAMPLE_INVALID = 3'd4;
    localparam logic [2:0] CLR_NOT_A_CLEAR    = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] REG_CURRENT_LIMIT = 2'd0;
    localparam logic [1:0] REG_BUS_MIN       = 2'd1;
    localparam logic [1:0] REG_BUS_MAX       = 2'd2;
    localparam logic [1:0] REG_OV_COUNT      = 2'd3;

    // Register widths and reset values.
    localparam int CFG_DATA_W = 20;
    localparam logic [14:0] CURRENT_LIMIT_RST = 15'd12000;
    localparam logic [19:0] BUS_MIN_RST       = 20'd8000;
    localparam logic [19:0] BUS_MAX_RST       = 20'd350000;
    localparam logic [7:0]  OV_COUNT_RST      = 8'd10;
    localparam logic [7:0]  OV_RUN_MAX        = 8'd255;

    typedef struct packed {
        logic [14:0] current_limit_ma;
        logic [19:0] bus_min_mv;
        logic [19:0] bus_max_mv;
        logic [7:0]  overvolt_count_limit;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         func;
        logic               frame_present;
        logic [3:0]         frame_status;
        logic signed [15:0] shunt1_ma;
        logic signed [15:0] shunt2_ma;
        logic [19:0]        bus_mv;
        logic [3:0]         reason_in;
        logic               control_active;
        logic               sd_lines_high;
        logic               sample_ok;
        logic               break_pending;
    } item_t;

    typedef struct packed {
        logic       fault_flag;
        logic [3:0] latched_reason;
        logic [7:0] overvolt_run;
    } state_t;

    typedef struct packed {
        logic       fault_latched;
        logic [3:0] fault_code;
        logic [2:0] clear_result;
        logic       pwm_kill;
    } result_t;

    // Map a frame status to the reason it latches.
    function automatic logic [3:0] status_to_code(input logic [3:0] status);
        logic [3:0] code;
        case (status) inside
            STAT_VALID:                                   code = CODE_NONE;
            STAT_OVERRUN:                                 code = CODE_OVERRUN;
            STAT_QUEUE_OVERRUN:                           code = CODE_QUEUE_OVERRUN;
            STAT_EOS_TIMEOUT, STAT_NOT_ARMED:             code = CODE_TIMEOUT;
            STAT_WINDOW_BAD:                              code = CODE_WINDOW;
            STAT_MAP_UNVERIFIED, STAT_CAL_BAD, STAT_SATURATED:
                                                          code = CODE_MAP;
            default:                                      code = CODE_DESYNC;
        endcase
        return code;
    endfunction

    // Magnitude of a signed 16-bit current, 0 to 32768.
    function automatic logic [16:0] mag16(input logic signed [15:0] value);
        logic [16:0] ext;
        ext = {value[15], value};
        return value[15] ? (17'd0 - ext) : ext;
    endfunction

endpackage

`default_nettype wire

/* rtl/ifpl_cfg.sv */
// Configuration registers of the inverter fault latch.
`default_nettype none

module ifpl_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [ifpl_pkg::CFG_DATA_W-1:0] cfg_data,
    output ifpl_pkg::cfg_t                       cfg
);

    ifpl_pkg::cfg_t cfg_reg;

    // Register file, written one register at a time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.current_limit_ma     <= ifpl_pkg::CURRENT_LIMIT_RST;
            cfg_reg.bus_min_mv           <= ifpl_pkg::BUS_MIN_RST;
            cfg_reg.bus_max_mv           <= ifpl_pkg::BUS_MAX_RST;
            cfg_reg.overvolt_count_limit <= ifpl_pkg::OV_COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                ifpl_pkg::REG_CURRENT_LIMIT: cfg_reg.current_limit_ma <= cfg_data[14:0];
                ifpl_pkg::REG_BUS_MIN:       cfg_reg.bus_min_mv       <= cfg_data[19:0];
                ifpl_pkg::REG_BUS_MAX:       cfg_reg.bus_max_mv       <= cfg_data[19:0];
                ifpl_pkg::REG_OV_COUNT:      cfg_reg.overvolt_count_limit <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/ifpl_eval.sv */
// Single-pass evaluation of one word against the latch state and limits.
`default_nettype none

module ifpl_eval (
    input  wire ifpl_pkg::item_t   item,
    input  wire ifpl_pkg::state_t  state,
    input  wire ifpl_pkg::cfg_t    cfg,
    output ifpl_pkg::state_t       state_next,
    output ifpl_pkg::result_t      result
);

    logic [16:0] i1_mag;
    logic [16:0] i2_mag;
    logic [16:0] limit_ext;
    logic [16:0] half_ext;
    logic        over_current;
    logic        over_half;
    logic        bus_high;
    logic        bus_low;
    logic [7:0]  run_sat;

    // Magnitudes and limit compares shared by the frame and clear paths.
    assign i1_mag       = ifpl_pkg::mag16(item.shunt1_ma);
    assign i2_mag       = ifpl_pkg::mag16(item.shunt2_ma);
    assign limit_ext    = {2'b00, cfg.current_limit_ma};
    assign half_ext     = {3'b000, cfg.current_limit_ma[14:1]};
    assign over_current = (i1_mag > limit_ext) || (i2_mag > limit_ext);
    assign over_half    = (i1_mag > half_ext) || (i2_mag > half_ext);
    assign bus_high     = item.bus_mv > cfg.bus_max_mv;
    assign bus_low      = item.bus_mv < cfg.bus_min_mv;
    assign run_sat      = (state.overvolt_run == ifpl_pkg::OV_RUN_MAX) ?
                          state.overvolt_run : state.overvolt_run + 8'd1;

    // Decide the next latch state and the result word.
    always_comb
    begin
        logic       set_req;
        logic [3:0] set_code;
        logic [2:0] clr;
        set_req    = 1'b0;
        set_code   = ifpl_pkg::CODE_NONE;
        clr        = ifpl_pkg::CLR_NOT_A_CLEAR;
        state_next = state;

        case (item.func)
            ifpl_pkg::FUNC_CHECK, ifpl_pkg::FUNC_CAPTURE:
            begin
                if (!state.fault_flag)
                begin
                    if (!item.frame_present)
                    begin
                        set_req  = 1'b1;
                        set_code = ifpl_pkg::CODE_FRAME_COPY;
                    end
                    else if (item.func == ifpl_pkg::FUNC_CAPTURE)
                    begin
                        // Capture frames also pass the map-unverified status.
                        if (item.frame_status != ifpl_pkg::STAT_VALID &&
                            item.frame_status != ifpl_pkg::STAT_MAP_UNVERIFIED)
                        begin
                            set_req  = 1'b1;
                            set_code = ifpl_pkg::status_to_code(item.frame_status);
                        end
                    end
                    else if (item.frame_status != ifpl_pkg::STAT_VALID)
                    begin
                        set_req  = 1'b1;
                        set_code = ifpl_pkg::status_to_code(item.frame_status);
                    end
                    else if (over_current)
                    begin
                        set_req  = 1'b1;
                        set_code = ifpl_pkg::CODE_OVERCURRENT;
                    end
                    else if (bus_high)
                    begin
                        // Over-voltage must persist until the run reaches overvolt_count_limit.
                        state_next.overvolt_run = run_sat;
                        if (run_sat >= cfg.overvolt_count_limit)
                        begin
                            set_req  = 1'b1;
                            set_code = ifpl_pkg::CODE_BUS_HIGH;
                        end
                    end
                    else
                    begin
                        state_next.overvolt_run = 8'd0;
                        if (bus_low)
                        begin
                            set_req  = 1'b1;
                            set_code = ifpl_pkg::CODE_BUS_LOW;
                        end
                    end
                end
            end
            ifpl_pkg::FUNC_EXTERNAL:
            begin
                if (!state.fault_flag)
                begin
                    set_req  = 1'b1;
                    set_code = item.reason_in;
                end
            end
            default:
            begin
                // Clear request: checks in priority order.
                if (!state.fault_flag)
                    clr = ifpl_pkg::CLR_NOT_LATCHED;
                else if (item.control_active)
                    clr = ifpl_pkg::CLR_CONTROL_ACTIVE;
                else if (!item.sd_lines_high)
                    clr = ifpl_pkg::CLR_UNSAFE;
                else if (!item.sample_ok)
                    clr = ifpl_pkg::CLR_SAMPLE_INVALID;
                else if (bus_low || bus_high || over_half || item.break_pending)
                    clr = ifpl_pkg::CLR_UNSAFE;
                else
                begin
                    clr                       = ifpl_pkg::CLR_OK;
                    state_next.fault_flag     = 1'b0;
                    state_next.latched_reason = ifpl_pkg::CODE_NONE;
                    state_next.overvolt_run   = 8'd0;
                end
            end
        endcase

        if (set_req)
        begin
            state_next.fault_flag     = 1'b1;
            state_next.latched_reason = set_code;
        end

        result.fault_latched = state_next.fault_flag;
        result.fault_code    = state_next.latched_reason;
        result.clear_result  = clr;
        result.pwm_kill      = set_req;
    end

endmodule

`default_nettype wire

/* rtl/inverter_fault_protection_latch.sv */
// Top level of the inverter fault latch: input register, evaluation, result register.
//
//   Channel  | Handshake              | Word
//   ---------+------------------------+----------------------------------------------
//   input    | in_valid / in_ready    | func, frame fields, reason_in, clear inputs
//   result   | out_valid / out_ready  | fault_latched, fault_code, clear_result, pwm_kill
//   config   | cfg_wr_en              | cfg_index, cfg_data
//
// A word is registered at its input, evaluated against the latch state, and its
// result is registered once the result register is free to take it.
// One word per cycle is sustained while out_ready holds, and the latch
// state updates as the result is stored.
// A stalled result register holds its word, and the input register fills behind it.
// Reset clears the latch, the over-voltage run and both valid flags, and loads the
// default limits.
`default_nettype none

module inverter_fault_protection_latch (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      func,
    input  wire logic                            frame_present,
    input  wire logic [3:0]                      frame_status,
    input  wire logic signed [15:0]              shunt1_ma,
    input  wire logic signed [15:0]              shunt2_ma,
    input  wire logic [19:0]                     bus_mv,
    input  wire logic [3:0]                      reason_in,
    input  wire logic                            control_active,
    input  wire logic                            sd_lines_high,
    input  wire logic                            sample_ok,
    input  wire logic                            break_pending,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 fault_latched,
    output logic [3:0]                           fault_code,
    output logic [2:0]                           clear_result,
    output logic                                 pwm_kill,
    input  wire logic                            cfg_wr_en,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [ifpl_pkg::CFG_DATA_W-1:0] cfg_data
);

    ifpl_pkg::cfg_t    cfg;
    ifpl_pkg::item_t   item_reg;
    ifpl_pkg::state_t  state_reg;
    ifpl_pkg::state_t  state_next;
    ifpl_pkg::result_t res_next;
    ifpl_pkg::result_t res_reg;
    logic              item_valid_reg;
    logic              out_valid_reg;
    logic              out_free;
    logic              item_fire;
    logic              in_fire;

    ifpl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ifpl_eval u_eval (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .result     (res_next)
    );

    // Pipeline flow control.
    assign out_free  = !out_valid_reg || out_ready;
    assign item_fire = item_valid_reg && out_free;
    assign in_ready  = !item_valid_reg || out_free;
    assign in_fire   = in_valid && in_ready;

    // Valid flags and the latch state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            item_valid_reg <= in_fire || (item_valid_reg && !item_fire);
            if (item_fire)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.func           <= func;
            item_reg.frame_present  <= frame_present;
            item_reg.frame_status   <= frame_status;
            item_reg.shunt1_ma      <= shunt1_ma;
            item_reg.shunt2_ma      <= shunt2_ma;
            item_reg.bus_mv         <= bus_mv;
            item_reg.reason_in      <= reason_in;
            item_reg.control_active <= control_active;
            item_reg.sd_lines_high  <= sd_lines_high;
            item_reg.sample_ok      <= sample_ok;
            item_reg.break_pending  <= break_pending;
        end
        if (item_fire)
        begin
            res_reg <= res_next;
        end
    end

    // Result word outputs.
    assign out_valid     = out_valid_reg;
    assign fault_latched = res_reg.fault_latched;
    assign fault_code    = res_reg.fault_code;
    assign clear_result  = res_reg.clear_result;
    assign pwm_kill      = res_reg.pwm_kill;

endmodule

`default_nettype wire

/* rtl/ifpl_checker.sv */
// Port-level checker for the inverter fault latch and its bind statement.
`default_nettype none

module ifpl_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       fault_latched,
    input wire logic [3:0] fault_code,
    input wire logic [2:0] clear_result,
    input wire logic       pwm_kill
);

    // A word that newly latched a fault shows the latch set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pwm_kill) |-> fault_latched)
        else $error("pwm_kill without a latched fault");

    // With the latch open the reason is always none.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !fault_latched) |-> (fault_code == ifpl_pkg::CODE_NONE))
        else $error("reason code held while the latch is open");

    // A successful or refused-for-not-latched clear leaves the latch open.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (clear_result == ifpl_pkg::CLR_OK ||
                       clear_result == ifpl_pkg::CLR_NOT_LATCHED))
        |-> (!fault_latched && !pwm_kill))
        else $error("clear result disagrees with the latch");

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        (out_valid && $stable(fault_latched) && $stable(fault_code) &&
         $stable(clear_result) && $stable(pwm_kill)))
        else $error("stalled result word changed");

endmodule

bind inverter_fault_protection_latch ifpl_checker u_ifpl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .fault_latched (fault_latched),
    .fault_code    (fault_code),
    .clear_result  (clear_result),
    .pwm_kill      (pwm_kill)
);

`default_nettype wire
